[hw/rtl/qrm_pkg.sv]
// Shared types and constants for the quaternion to rotation matrix block.
// No dependencies; used by qrm_divider and quaternion_to_rotation_matrix.
`default_nettype none
package qrm_pkg;

   localparam int OUT_FRAC_BITS_DEF = 14;
   localparam int NUM_ENTRIES       = 9;
   // quadrance of four 16-bit signed values reaches 2^32
   localparam int Q_W               = 33;
   // remainder after the doubling step stays below 2 * quadrance
   localparam int REM_W             = 34;
   // signed numerator, magnitude up to the quadrance
   localparam int NUM_W             = 34;

   typedef struct packed {
      logic valid;
      logic zero;
   } ctl_type;

endpackage
`default_nettype wire

[hw/rtl/qrm_divider.sv]
// Pipelined restoring divider, nine lanes sharing one divisor, one quotient bit per stage.
// Depends on qrm_pkg.
`default_nettype none
module qrm_divider #(
   parameter int OUT_FRAC_BITS = qrm_pkg::OUT_FRAC_BITS_DEF,
   localparam int NQ = OUT_FRAC_BITS + 2
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire qrm_pkg::ctl_type         stage_ctl,
   input  wire logic [qrm_pkg::Q_W-1:0]  stage_q,
   input  wire logic [qrm_pkg::Q_W-1:0]  stage_mag [qrm_pkg::NUM_ENTRIES],
   input  wire logic                     stage_neg [qrm_pkg::NUM_ENTRIES],
   output qrm_pkg::ctl_type              div_ctl,
   output logic [NQ-1:0]                 div_quo [qrm_pkg::NUM_ENTRIES],
   output logic                          div_neg [qrm_pkg::NUM_ENTRIES]
);
   import qrm_pkg::*;

   ctl_type          ctl_ff [NQ];
   logic [Q_W-1:0]   q_ff   [NQ];
   logic [REM_W-1:0] rem_ff [NQ][NUM_ENTRIES];
   logic [NQ-1:0]    quo_ff [NQ][NUM_ENTRIES];
   logic             neg_ff [NQ][NUM_ENTRIES];

   for (genvar k = 0; k < NQ; k++) begin : g_step
      ctl_type          ctl_in;
      logic [Q_W-1:0]   q_src;
      logic [REM_W-1:0] trial   [NUM_ENTRIES];
      logic [NQ-1:0]    quo_src [NUM_ENTRIES];
      logic             neg_in  [NUM_ENTRIES];
      logic [REM_W-1:0] rem_in  [NUM_ENTRIES];
      logic [NQ-1:0]    quo_in  [NUM_ENTRIES];

      if (k == 0) begin : g_first
         // first step yields the integer bit: magnitude never exceeds the divisor
         always_comb begin
            ctl_in = stage_ctl;
            q_src  = stage_q;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
               trial[i]   = {1'b0, stage_mag[i]};
               quo_src[i] = '0;
               neg_in[i]  = stage_neg[i];
            end
         end
      end else begin : g_next
         always_comb begin
            ctl_in = ctl_ff[k-1];
            q_src  = q_ff[k-1];
            for (int i = 0; i < NUM_ENTRIES; i++) begin
               trial[i]   = {rem_ff[k-1][i][REM_W-2:0], 1'b0};
               quo_src[i] = quo_ff[k-1][i];
               neg_in[i]  = neg_ff[k-1][i];
            end
         end
      end

      always_comb begin
         logic [REM_W:0] diff;
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            diff = {1'b0, trial[i]} - {2'b00, q_src};
            if (!diff[REM_W]) begin
               rem_in[i] = diff[REM_W-1:0];
               quo_in[i] = {quo_src[i][NQ-2:0], 1'b1};
            end else begin
               rem_in[i] = trial[i];
               quo_in[i] = {quo_src[i][NQ-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else begin
            ctl_ff[k] <= ctl_in;
         end
         q_ff[k] <= q_src;
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            rem_ff[k][i] <= rem_in[i];
            quo_ff[k][i] <= quo_in[i];
            neg_ff[k][i] <= neg_in[i];
         end
      end
   end

   assign div_ctl = ctl_ff[NQ-1];
   always_comb begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         div_quo[i] = quo_ff[NQ-1][i];
         div_neg[i] = neg_ff[NQ-1][i];
      end
   end

endmodule
`default_nettype wire

[hw/rtl/quaternion_to_rotation_matrix.sv]
// Top level: quaternion in, normalized 3x3 rotation matrix out.
// Depends on qrm_pkg and qrm_divider.
`default_nettype none
// Accepts one quaternion every cycle (busy is always low) and delivers its
// matrix strobed by rsp_valid for one cycle; the receiver cannot stall the
// block. The pipeline is a product stage, a sum stage, the divider, which
// resolves one quotient bit per stage for all nine entries at once, and a
// rounding stage. Each entry is its numerator over the quadrance, rounded
// to nearest with ties away from zero, saturated, then cleaned against
// csr_wr_data's last value. An all-zero quaternion gives the identity and
// rsp_zero_quaternion.
module quaternion_to_rotation_matrix #(
   parameter int OUT_FRAC_BITS = qrm_pkg::OUT_FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [15:0] req_quat_w,
   input  wire logic signed [15:0] req_quat_x,
   input  wire logic signed [15:0] req_quat_y,
   input  wire logic signed [15:0] req_quat_z,
   input  wire logic               csr_wr_en,
   input  wire logic [7:0]         csr_wr_data,
   output logic                    rsp_valid,
   output logic signed [15:0]      rsp_r00,
   output logic signed [15:0]      rsp_r01,
   output logic signed [15:0]      rsp_r02,
   output logic signed [15:0]      rsp_r10,
   output logic signed [15:0]      rsp_r11,
   output logic signed [15:0]      rsp_r12,
   output logic signed [15:0]      rsp_r20,
   output logic signed [15:0]      rsp_r21,
   output logic signed [15:0]      rsp_r22,
   output logic                    rsp_zero_quaternion
);
   import qrm_pkg::*;

   localparam int NQ  = OUT_FRAC_BITS + 2;
   localparam int CW  = (NQ > 17) ? NQ : 17;
   localparam int LAT = NQ + 3;

   logic [7:0] thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= '0;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   assign busy = 1'b0;

   // product stage
   logic               valid_a_ff;
   logic signed [31:0] ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [31:0] xy_ff, xz_ff, xw_ff, yz_ff, yw_ff, zw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= start;
      end
      ww_ff <= req_quat_w * req_quat_w;
      xx_ff <= req_quat_x * req_quat_x;
      yy_ff <= req_quat_y * req_quat_y;
      zz_ff <= req_quat_z * req_quat_z;
      xy_ff <= req_quat_x * req_quat_y;
      xz_ff <= req_quat_x * req_quat_z;
      xw_ff <= req_quat_x * req_quat_w;
      yz_ff <= req_quat_y * req_quat_z;
      yw_ff <= req_quat_y * req_quat_w;
      zw_ff <= req_quat_z * req_quat_w;
   end

   // sum stage: quadrance, numerators, sign and magnitude
   ctl_type        ctl_b_ff, ctl_b_in;
   logic [Q_W-1:0] q_b_ff, q_b_in;
   logic [Q_W-1:0] mag_b_ff [NUM_ENTRIES];
   logic [Q_W-1:0] mag_b_in [NUM_ENTRIES];
   logic           neg_b_ff [NUM_ENTRIES];
   logic           neg_b_in [NUM_ENTRIES];

   always_comb begin
      logic signed [NUM_W-1:0] ww, xx, yy, zz, xy, xz, xw, yz, yw, zw;
      logic signed [NUM_W-1:0] num [NUM_ENTRIES];
      logic signed [NUM_W-1:0] d;
      logic [Q_W-1:0]          q;
      ww = NUM_W'(ww_ff); xx = NUM_W'(xx_ff); yy = NUM_W'(yy_ff); zz = NUM_W'(zz_ff);
      xy = NUM_W'(xy_ff); xz = NUM_W'(xz_ff); xw = NUM_W'(xw_ff);
      yz = NUM_W'(yz_ff); yw = NUM_W'(yw_ff); zw = NUM_W'(zw_ff);
      q = Q_W'(unsigned'(ww + xx + yy + zz));
      num[0] = ww + xx - yy - zz;
      d = xy - zw; num[1] = {d[NUM_W-2:0], 1'b0};
      d = xz + yw; num[2] = {d[NUM_W-2:0], 1'b0};
      d = xy + zw; num[3] = {d[NUM_W-2:0], 1'b0};
      num[4] = ww - xx + yy - zz;
      d = yz - xw; num[5] = {d[NUM_W-2:0], 1'b0};
      d = xz - yw; num[6] = {d[NUM_W-2:0], 1'b0};
      d = yz + xw; num[7] = {d[NUM_W-2:0], 1'b0};
      num[8] = ww - xx - yy + zz;
      ctl_b_in.valid = valid_a_ff;
      ctl_b_in.zero  = (q == '0);
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         neg_b_in[i] = num[i][NUM_W-1];
         d           = neg_b_in[i] ? -num[i] : num[i];
         mag_b_in[i] = d[Q_W-1:0];
      end
      q_b_in = q;
      if (ctl_b_in.zero) begin
         // identity as 1/1 on the diagonal, 0/1 elsewhere
         q_b_in = Q_W'(1);
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            neg_b_in[i] = 1'b0;
            mag_b_in[i] = (i == 0 || i == 4 || i == 8) ? Q_W'(1) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_b_ff <= '0;
      end else begin
         ctl_b_ff <= ctl_b_in;
      end
      q_b_ff <= q_b_in;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         mag_b_ff[i] <= mag_b_in[i];
         neg_b_ff[i] <= neg_b_in[i];
      end
   end

   ctl_type       div_ctl;
   logic [NQ-1:0] div_quo [NUM_ENTRIES];
   logic          div_neg [NUM_ENTRIES];

   qrm_divider #(
      .OUT_FRAC_BITS(OUT_FRAC_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .stage_ctl (ctl_b_ff),
      .stage_q   (q_b_ff),
      .stage_mag (mag_b_ff),
      .stage_neg (neg_b_ff),
      .div_ctl   (div_ctl),
      .div_quo   (div_quo),
      .div_neg   (div_neg)
   );

   // round, saturate, clean and apply sign
   logic               valid_ff;
   logic               zero_ff;
   logic signed [15:0] ent_ff [NUM_ENTRIES];
   logic signed [15:0] ent_in [NUM_ENTRIES];

   always_comb begin
      logic [NQ:0]   rp1;
      logic [CW-1:0] r;
      logic [CW-1:0] lim;
      logic [15:0]   r16;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         rp1 = {1'b0, div_quo[i]} + (NQ+1)'(1);
         r   = CW'(rp1[NQ:1]);
         lim = div_neg[i] ? CW'(32768) : CW'(32767);
         if (r > lim) begin
            r = lim;
         end
         if (r < CW'(thresh_ff)) begin
            r = '0;
         end
         r16       = r[15:0];
         ent_in[i] = div_neg[i] ? signed'(-r16) : signed'(r16);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= div_ctl.valid;
      end
      zero_ff <= div_ctl.zero;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         ent_ff[i] <= ent_in[i];
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_zero_quaternion = zero_ff;
   assign rsp_r00 = ent_ff[0];
   assign rsp_r01 = ent_ff[1];
   assign rsp_r02 = ent_ff[2];
   assign rsp_r10 = ent_ff[3];
   assign rsp_r11 = ent_ff[4];
   assign rsp_r12 = ent_ff[5];
   assign rsp_r20 = ent_ff[6];
   assign rsp_r21 = ent_ff[7];
   assign rsp_r22 = ent_ff[8];

   logic [16:0] r00_mag;
   assign r00_mag = rsp_r00[15] ? 17'(-$signed({rsp_r00[15], rsp_r00})) : 17'(rsp_r00);

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LAT rsp_valid)
      else $error("accepted transfer did not reach the result port on time");

   a_zero_offdiag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_quaternion |->
         rsp_r01 == 16'sd0 && rsp_r02 == 16'sd0 && rsp_r10 == 16'sd0 &&
         rsp_r12 == 16'sd0 && rsp_r20 == 16'sd0 && rsp_r21 == 16'sd0)
      else $error("zero quaternion gave nonzero off-diagonal entries");

   a_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> r00_mag == 17'd0 || r00_mag >= 17'(thresh_ff))
      else $error("entry below cleaning threshold was not forced to zero");

endmodule
`default_nettype wire
